FILE: rtl/mws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mws_pkg
// Shared types, register indexes and constants of the mecanum wheel solver.
// ----------------------------------------------------------------------------
package mws_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned DIV_STEPS   = 16;
	localparam logic signed [25:0] RADIAN_Q16 = 26'sd1144;

	localparam logic [2:0] REG_ROT_ARM   = 3'd0;
	localparam logic [2:0] REG_OFS_X     = 3'd1;
	localparam logic [2:0] REG_OFS_Y     = 3'd2;
	localparam logic [2:0] REG_RPM_RATIO = 3'd3;
	localparam logic [2:0] REG_LIM_VX    = 3'd4;
	localparam logic [2:0] REG_LIM_VY    = 3'd5;
	localparam logic [2:0] REG_LIM_TURN  = 3'd6;
	localparam logic [2:0] REG_LIM_WHEEL = 3'd7;

	typedef struct packed {
		logic        [11:0] rotation_arm_mm;
		logic signed [11:0] centre_offset_x_mm;
		logic signed [11:0] centre_offset_y_mm;
		logic        [19:0] rpm_ratio_q16;
		logic        [14:0] limit_vx;
		logic        [14:0] limit_vy;
		logic        [14:0] limit_turn;
		logic        [14:0] limit_wheel_rpm;
	} mws_cfg_t;

	typedef struct packed {
		logic signed [15:0] speed_x;
		logic signed [15:0] speed_y;
		logic signed [15:0] turn_rate;
	} mws_item_t;

	typedef struct packed {
		logic signed [15:0] front_right_rpm;
		logic signed [15:0] front_left_rpm;
		logic signed [15:0] back_left_rpm;
		logic signed [15:0] back_right_rpm;
		logic               was_scaled;
	} mws_result_t;

endpackage

FILE: rtl/mws_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mws_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module mws_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= nxt(wr_q);
			if (do_pop)  rd_q <= nxt(rd_q);
			if (do_push && !do_pop)      cnt_q <= CW'(cnt_q + 1'b1);
			else if (do_pop && !do_push) cnt_q <= CW'(cnt_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= din;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH)) else $error("queue count past depth");
	a_push_fill: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |=> !empty) else $error("queue empty after push");
	a_pop_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push && cnt_q == CW'(1)) |=> empty)
		else $error("queue not empty after last pop");

endmodule

FILE: rtl/mws_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mws_front
// Accept commands, clamp each component to its limit, feed the work queue.
// ----------------------------------------------------------------------------
module mws_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  mws_pkg::mws_item_t item,
	input  mws_pkg::mws_cfg_t  cfg,
	output logic               q_push,
	output mws_pkg::mws_item_t q_item,
	input  logic               q_full
);
	import mws_pkg::*;

	logic      v_s1;
	mws_item_t item_s1;
	logic      accept;

	function automatic logic signed [15:0] clamp(input logic signed [15:0] v,
			input logic [14:0] lim);
		logic signed [16:0] l, x;
		l = $signed({2'b00, lim});
		x = 17'(v);
		if (x > l)       return 16'(l);
		else if (x < -l) return 16'(-l);
		else             return v;
	endfunction

	assign full   = v_s1 && q_full;
	assign accept = push && !full;
	assign q_push = v_s1 && !q_full;
	assign q_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.speed_x   <= clamp(item.speed_x, cfg.limit_vx);
			item_s1.speed_y   <= clamp(item.speed_y, cfg.limit_vy);
			item_s1.turn_rate <= clamp(item.turn_rate, cfg.limit_turn);
		end
	end

endmodule

FILE: rtl/mws_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mws_back
// Wheel kinematics pipeline with proportional limit scaling by division.
// ----------------------------------------------------------------------------
module mws_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mws_pkg::mws_cfg_t    cfg,
	input  logic                 q_empty,
	input  mws_pkg::mws_item_t   q_item,
	output logic                 q_pop,
	input  logic                 o_full,
	output logic                 o_push,
	output mws_pkg::mws_result_t o_res
);
	import mws_pkg::*;

	localparam int unsigned NS = DIV_STEPS;

	logic en;
	logic [4:0] v_q;
	logic [NS:0] dv_q;

	logic signed [16:0] lin_s1 [4];
	logic signed [25:0] rot_s1 [4];
	logic signed [15:0] vz_s1;
	logic signed [42:0] sum_s2 [4];
	logic        [40:0] plo_s3 [4], phi_s3 [4];
	logic               neg_s3 [4];
	logic signed [15:0] w_s4 [4];
	logic signed [15:0] w_s5 [4];
	logic        [15:0] a_s5 [4];
	logic        [15:0] m_s5;
	logic               scl_s5;

	logic signed [15:0] w_d_q   [NS+1][4];
	logic        [15:0] rem_d_q [NS+1][4];
	logic        [15:0] lo_d_q  [NS+1][4];
	logic        [15:0] quo_d_q [NS+1][4];
	logic        [15:0] m_d_q   [NS+1];
	logic               scl_d_q [NS+1];

	logic signed [16:0] vx, vy;
	logic signed [13:0] r, ox, oy;
	logic signed [16:0] lin_c [4];
	logic signed [13:0] arm_c [4];
	logic        [15:0] mx01, mx23, mx;
	logic signed [15:0] fin [4];

	function automatic logic [15:0] a_s4(input int i);
		return w_s4[i][15] ? 16'(16'd0 - w_s4[i]) : w_s4[i];
	endfunction

	function automatic logic signed [15:0] sat(input logic [40:0] pl,
			input logic [40:0] ph, input logic neg);
		logic [62:0] mag;
		logic [30:0] q;
		mag = (63'(ph) << 21) + 63'(pl);
		q   = mag[62:32];
		if (neg) return (q > 31'd32768) ? 16'sh8000 : 16'(31'd0 - q);
		else     return (q > 31'd32767) ? 16'sh7FFF : q[15:0];
	endfunction

	assign en    = !(dv_q[NS] && o_full);
	assign q_pop = en && !q_empty;

	assign vx = 17'(q_item.speed_x);
	assign vy = 17'(q_item.speed_y);
	assign r  = $signed({2'b00, cfg.rotation_arm_mm});
	assign ox = 14'(cfg.centre_offset_x_mm);
	assign oy = 14'(cfg.centre_offset_y_mm);

	assign lin_c[0] = vx + vy;
	assign lin_c[1] = vx - vy;
	assign lin_c[2] = -vx - vy;
	assign lin_c[3] = -vx + vy;
	assign arm_c[0] = r - ox + oy;
	assign arm_c[1] = r - ox - oy;
	assign arm_c[2] = r + ox - oy;
	assign arm_c[3] = r + ox + oy;

	assign mx01 = (a_s4(0) > a_s4(1)) ? a_s4(0) : a_s4(1);
	assign mx23 = (a_s4(2) > a_s4(3)) ? a_s4(2) : a_s4(3);
	assign mx   = (mx01 > mx23) ? mx01 : mx23;

	// v_q[4] marks the maximum-search stage; dv_q[k] marks divider step k.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q  <= '0;
			dv_q <= '0;
		end else if (en) begin
			v_q  <= {v_q[3:0], q_pop};
			dv_q <= {dv_q[NS-1:0], v_q[4]};
		end
	end

	always_ff @(posedge clk) begin
		logic signed [41:0] prod;
		logic signed [42:0] s;
		logic        [41:0] am;
		logic        [16:0] t;
		if (en) begin
			vz_s1 <= q_item.turn_rate;
			for (int i = 0; i < 4; i++) begin
				lin_s1[i] <= lin_c[i];
				rot_s1[i] <= 26'(arm_c[i]) * RADIAN_Q16;
				prod = 42'(vz_s1) * 42'(rot_s1[i]);
				sum_s2[i] <= (43'(lin_s1[i]) <<< 16) - 43'(prod);
				s  = sum_s2[i];
				am = s[42] ? 42'(-s) : 42'(s);
				neg_s3[i] <= s[42];
				plo_s3[i] <= 41'(am[20:0]) * 41'(cfg.rpm_ratio_q16);
				phi_s3[i] <= 41'(am[41:21]) * 41'(cfg.rpm_ratio_q16);
				w_s4[i] <= sat(plo_s3[i], phi_s3[i], neg_s3[i]);
				w_s5[i] <= w_s4[i];
				a_s5[i] <= a_s4(i);
			end
			m_s5   <= mx;
			scl_s5 <= (mx > {1'b0, cfg.limit_wheel_rpm});
			// enter divider: numerator |w|*limit, quotient has 16 bits
			m_d_q[0]   <= m_s5;
			scl_d_q[0] <= scl_s5;
			for (int i = 0; i < 4; i++) begin
				logic [30:0] num;
				num = 31'(a_s5[i]) * 31'(cfg.limit_wheel_rpm);
				w_d_q[0][i]   <= w_s5[i];
				rem_d_q[0][i] <= {1'b0, num[30:16]};
				lo_d_q[0][i]  <= num[15:0];
				quo_d_q[0][i] <= '0;
			end
			for (int k = 0; k < NS; k++) begin
				m_d_q[k+1]   <= m_d_q[k];
				scl_d_q[k+1] <= scl_d_q[k];
				for (int i = 0; i < 4; i++) begin
					t = {rem_d_q[k][i], lo_d_q[k][i][15]};
					w_d_q[k+1][i]  <= w_d_q[k][i];
					lo_d_q[k+1][i] <= {lo_d_q[k][i][14:0], 1'b0};
					if (t >= 17'(m_d_q[k])) begin
						rem_d_q[k+1][i] <= 16'(t - 17'(m_d_q[k]));
						quo_d_q[k+1][i] <= {quo_d_q[k][i][14:0], 1'b1};
					end else begin
						rem_d_q[k+1][i] <= t[15:0];
						quo_d_q[k+1][i] <= {quo_d_q[k][i][14:0], 1'b0};
					end
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (!scl_d_q[NS])          fin[i] = w_d_q[NS][i];
			else if (w_d_q[NS][i][15]) fin[i] = 16'(16'd0 - quo_d_q[NS][i]);
			else                       fin[i] = quo_d_q[NS][i];
		end
	end

	assign o_push               = en && dv_q[NS];
	assign o_res.front_right_rpm = fin[0];
	assign o_res.front_left_rpm  = fin[1];
	assign o_res.back_left_rpm   = fin[2];
	assign o_res.back_right_rpm  = fin[3];
	assign o_res.was_scaled      = scl_d_q[NS];

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(o_push && o_full)) else $error("result pushed into full queue");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(dv_q)) else $error("pipeline moved while stalled");
	a_scaled_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_q[NS] && scl_d_q[NS]) |-> (quo_d_q[NS][0] <= {1'b0, cfg.limit_wheel_rpm}))
		else $error("scaled wheel above limit");

endmodule

FILE: rtl/mecanum_wheel_speed_solver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_solver_top
// Four-wheel mecanum inverse kinematics with clamping and rpm limiting.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on a queue-style port: a transaction completes on a clock
//   edge with push high and full low. Results leave the same way: while empty
//   is low the oldest result sits on the result ports, and a transaction
//   completes on an edge with pop high.
//   Throughput is one command per cycle while full is low. From an accepted
//   command to its result showing, it passes one clamp stage, the work
//   queue register, five arithmetic stages (arm, rotate product, rpm multiply
//   split into two partial products, saturation, maximum search), a divider
//   entry stage and 16 pipelined restoring steps per wheel, and the write
//   into the result queue.
//   When the receiver stalls, the result queue fills, the back pipeline
//   holds, the work queue fills and then full rises; nothing is dropped.
//   Reset empties both queues and the pipeline and loads the default
//   register values. Configuration goes through the APB port: register i at
//   byte address 4*i, written on the access cycle; pready is tied high.
//   Write registers only while the block is idle.
// ----------------------------------------------------------------------------
module mecanum_wheel_speed_solver_top #(
	parameter int unsigned QUEUE_DEPTH = mws_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] speed_x,
	input  logic signed [15:0] speed_y,
	input  logic signed [15:0] turn_rate,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] front_right_rpm,
	output logic signed [15:0] front_left_rpm,
	output logic signed [15:0] back_left_rpm,
	output logic signed [15:0] back_right_rpm,
	output logic               was_scaled,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import mws_pkg::*;

	mws_cfg_t    cfg_q;
	mws_item_t   in_item, fq_in, fq_out;
	mws_result_t res_in, res_out;
	logic        fq_push, fq_full, fq_pop, fq_empty;
	logic        rq_push, rq_full;
	logic        wr_en;
	logic [2:0]  idx;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite && pready;

	// Register file: hold values, take a write on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rotation_arm_mm    <= 12'd375;
			cfg_q.centre_offset_x_mm <= '0;
			cfg_q.centre_offset_y_mm <= '0;
			cfg_q.rpm_ratio_q16      <= 20'd156299;
			cfg_q.limit_vx           <= 15'd3300;
			cfg_q.limit_vy           <= 15'd3300;
			cfg_q.limit_turn         <= 15'd300;
			cfg_q.limit_wheel_rpm    <= 15'd8500;
		end else if (wr_en) begin
			unique case (idx)
				REG_ROT_ARM:   cfg_q.rotation_arm_mm    <= pwdata[11:0];
				REG_OFS_X:     cfg_q.centre_offset_x_mm <= pwdata[11:0];
				REG_OFS_Y:     cfg_q.centre_offset_y_mm <= pwdata[11:0];
				REG_RPM_RATIO: cfg_q.rpm_ratio_q16      <= pwdata[19:0];
				REG_LIM_VX:    cfg_q.limit_vx           <= pwdata[14:0];
				REG_LIM_VY:    cfg_q.limit_vy           <= pwdata[14:0];
				REG_LIM_TURN:  cfg_q.limit_turn         <= pwdata[14:0];
				REG_LIM_WHEEL: cfg_q.limit_wheel_rpm    <= pwdata[14:0];
			endcase
		end
	end

	// Read back: zero-extend the addressed register.
	always_comb begin
		unique case (idx)
			REG_ROT_ARM:   prdata = 32'(cfg_q.rotation_arm_mm);
			REG_OFS_X:     prdata = 32'(unsigned'(cfg_q.centre_offset_x_mm));
			REG_OFS_Y:     prdata = 32'(unsigned'(cfg_q.centre_offset_y_mm));
			REG_RPM_RATIO: prdata = 32'(cfg_q.rpm_ratio_q16);
			REG_LIM_VX:    prdata = 32'(cfg_q.limit_vx);
			REG_LIM_VY:    prdata = 32'(cfg_q.limit_vy);
			REG_LIM_TURN:  prdata = 32'(cfg_q.limit_turn);
			REG_LIM_WHEEL: prdata = 32'(cfg_q.limit_wheel_rpm);
		endcase
	end

	assign in_item.speed_x   = speed_x;
	assign in_item.speed_y   = speed_y;
	assign in_item.turn_rate = turn_rate;

	// Front: accept and clamp.
	mws_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (in_item),
		.cfg    (cfg_q),
		.q_push (fq_push),
		.q_item (fq_in),
		.q_full (fq_full)
	);

	// Work queue between front and back.
	mws_fifo #(.WIDTH($bits(mws_item_t)), .DEPTH(QUEUE_DEPTH)) u_work_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.din    (fq_in),
		.full   (fq_full),
		.pop    (fq_pop),
		.dout   (fq_out),
		.empty  (fq_empty)
	);

	// Back: kinematics, saturation, limit scaling.
	mws_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (fq_empty),
		.q_item  (fq_out),
		.q_pop   (fq_pop),
		.o_full  (rq_full),
		.o_push  (rq_push),
		.o_res   (res_in)
	);

	// Result queue decouples the receiver from the pipeline.
	mws_fifo #(.WIDTH($bits(mws_result_t)), .DEPTH(QUEUE_DEPTH)) u_result_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.din    (res_in),
		.full   (rq_full),
		.pop    (pop),
		.dout   (res_out),
		.empty  (empty)
	);

	assign front_right_rpm = res_out.front_right_rpm;
	assign front_left_rpm  = res_out.front_left_rpm;
	assign back_left_rpm   = res_out.back_left_rpm;
	assign back_right_rpm  = res_out.back_right_rpm;
	assign was_scaled      = res_out.was_scaled;

endmodule

FILE: verif/mecanum_wheel_speed_solver_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_solver_top_tb
// Self-checking bench for the mecanum wheel speed solver. Commands are fed in
// random bursts through the push/full port, results drained with a random
// pop stall pattern and compared field by field against an in-bench wheel
// speed predictor. Register settings change between phases over APB.
// ----------------------------------------------------------------------------
module mecanum_wheel_speed_solver_top_tb;
	import mws_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic signed [15:0] speed_x;
	logic signed [15:0] speed_y;
	logic signed [15:0] turn_rate;
	logic               empty;
	logic               pop;
	logic signed [15:0] front_right_rpm;
	logic signed [15:0] front_left_rpm;
	logic signed [15:0] back_left_rpm;
	logic signed [15:0] back_right_rpm;
	logic               was_scaled;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [4:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	mecanum_wheel_speed_solver_top DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.speed_x(speed_x), .speed_y(speed_y), .turn_rate(turn_rate),
		.empty(empty), .pop(pop),
		.front_right_rpm(front_right_rpm), .front_left_rpm(front_left_rpm),
		.back_left_rpm(back_left_rpm), .back_right_rpm(back_right_rpm),
		.was_scaled(was_scaled),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	localparam int DRAIN_CYCLES = 60;

	mws_cfg_t    cfg_shadow;
	mws_item_t   cmd_pending[$];
	mws_result_t wheel_expected[$];
	int          mismatch_count = 0;
	bit          feed_enable = 0;

	// Wheel speed before limiting: truncate toward zero, saturate to int16.
	function automatic longint wheel_before_limit(longint lin, longint vz, longint arm);
		longint s;
		longint p;
		longint mag;
		s = lin * 65536 - vz * (arm * 1144);
		p = s * longint'(cfg_shadow.rpm_ratio_q16);
		mag = (p < 0 ? -p : p) >>> 32;
		if (p < 0) begin
			if (mag > 32768) mag = 32768;
			return -mag;
		end
		if (mag > 32767) mag = 32767;
		return mag;
	endfunction

	function automatic longint clamp_cmd(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic mws_result_t solve_wheels(mws_item_t cmd);
		longint vx, vy, vz, r, ox, oy, m, lim, a;
		longint w[4];
		mws_result_t res;
		vx = clamp_cmd(cmd.speed_x, cfg_shadow.limit_vx);
		vy = clamp_cmd(cmd.speed_y, cfg_shadow.limit_vy);
		vz = clamp_cmd(cmd.turn_rate, cfg_shadow.limit_turn);
		r  = cfg_shadow.rotation_arm_mm;
		ox = cfg_shadow.centre_offset_x_mm;
		oy = cfg_shadow.centre_offset_y_mm;
		lim = cfg_shadow.limit_wheel_rpm;
		w[0] = wheel_before_limit(vx + vy, vz, r - ox + oy);
		w[1] = wheel_before_limit(vx - vy, vz, r - ox - oy);
		w[2] = wheel_before_limit(-vx - vy, vz, r + ox - oy);
		w[3] = wheel_before_limit(-vx + vy, vz, r + ox + oy);
		m = 0;
		for (int i = 0; i < 4; i++) begin
			a = w[i] < 0 ? -w[i] : w[i];
			if (a > m) m = a;
		end
		res.was_scaled = m > lim;
		if (m > lim) begin
			// SV division truncates toward zero, as required
			for (int i = 0; i < 4; i++) w[i] = (w[i] * lim) / m;
		end
		res.front_right_rpm = w[0][15:0];
		res.front_left_rpm  = w[1][15:0];
		res.back_left_rpm   = w[2][15:0];
		res.back_right_rpm  = w[3][15:0];
		return res;
	endfunction

	always #1 clk = ~clk;

	// Driver: bursts of random length separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (push && !full) begin
			wheel_expected.push_back(solve_wheels(cmd_pending.pop_front()));
		end
		if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			push <= 1'b0;
		end else if (feed_enable && cmd_pending.size() > 0) begin
			// hold the current item while full stalls it
			if (!(push && full)) begin
				speed_x   <= cmd_pending[0].speed_x;
				speed_y   <= cmd_pending[0].speed_y;
				turn_rate <= cmd_pending[0].turn_rate;
			end
			push <= 1'b1;
			if (push && !full) begin
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end else begin
			push <= 1'b0;
		end
	end

	// Indices: what will be shown next is cmd_pending[0] after any pop above.
	// Because the pop happens before the drive in this block, cmd_pending[0]
	// at drive time is the next unsent item when the current one was taken.

	// Monitor with its own stall pattern.
	int stall_mode = 0;
	int stall_count = 0;
	always @(posedge clk) begin
		if (pop && !empty) begin
			if (wheel_expected.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) $display("unexpected result at %0t", $time);
			end else begin
				mws_result_t e;
				e = wheel_expected.pop_front();
				if (e.front_right_rpm !== front_right_rpm ||
				    e.front_left_rpm !== front_left_rpm ||
				    e.back_left_rpm !== back_left_rpm ||
				    e.back_right_rpm !== back_right_rpm ||
				    e.was_scaled !== was_scaled) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: exp %0d %0d %0d %0d %0b got %0d %0d %0d %0d %0b",
							e.front_right_rpm, e.front_left_rpm, e.back_left_rpm,
							e.back_right_rpm, e.was_scaled, front_right_rpm,
							front_left_rpm, back_left_rpm, back_right_rpm, was_scaled);
				end
			end
		end
		if (stall_count == 0) begin
			stall_mode  <= $urandom_range(0, 3);
			stall_count <= $urandom_range(5, 60);
		end else begin
			stall_count <= stall_count - 1;
		end
		case (stall_mode)
			0: pop <= 1'b1;
			1: pop <= $urandom_range(0, 1);
			2: pop <= ($urandom_range(0, 7) == 0);
			default: pop <= ($urandom_range(0, 3) != 0);
		endcase
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_ROT_ARM:   cfg_shadow.rotation_arm_mm    = value[11:0];
			REG_OFS_X:     cfg_shadow.centre_offset_x_mm = value[11:0];
			REG_OFS_Y:     cfg_shadow.centre_offset_y_mm = value[11:0];
			REG_RPM_RATIO: cfg_shadow.rpm_ratio_q16      = value[19:0];
			REG_LIM_VX:    cfg_shadow.limit_vx           = value[14:0];
			REG_LIM_VY:    cfg_shadow.limit_vy           = value[14:0];
			REG_LIM_TURN:  cfg_shadow.limit_turn         = value[14:0];
			default:       cfg_shadow.limit_wheel_rpm    = value[14:0];
		endcase
	endtask

	task automatic add_cmd(input int x, input int y, input int z);
		mws_item_t c;
		c.speed_x = 16'(x); c.speed_y = 16'(y); c.turn_rate = 16'(z);
		cmd_pending.push_back(c);
	endtask

	// Random command: mostly in the clamp range, some full-scale values.
	function automatic int rand_speed(int lim);
		case ($urandom_range(0, 4))
			0: return $signed(16'($urandom));
			1: return $urandom_range(0, 1) ? 32767 : -32768;
			default: return int'($urandom_range(0, 2 * lim + 20)) - lim - 10;
		endcase
	endfunction

	// Run queued commands through and wait until every result is back.
	task automatic run_phase();
		feed_enable = 1;
		while (cmd_pending.size() != 0) @(posedge clk);
		@(posedge clk);
		feed_enable = 0;
		while (wheel_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++)
			add_cmd(rand_speed(cfg_shadow.limit_vx), rand_speed(cfg_shadow.limit_vy),
				rand_speed(cfg_shadow.limit_turn));
		run_phase();
	endtask

	initial begin
		clk = 0; arst_n = 0; push = 0; pop = 0;
		speed_x = 0; speed_y = 0; turn_rate = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		cfg_shadow = '{375, 0, 0, 156299, 3300, 3300, 300, 8500};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, zero, each axis alone, clamps
		add_cmd(0, 0, 0);
		add_cmd(32767, 32767, 32767);
		add_cmd(-32768, -32768, -32768);
		add_cmd(3300, 0, 0);
		add_cmd(0, -3300, 0);
		add_cmd(0, 0, 300);
		add_cmd(0, 0, -301);
		add_cmd(1000, -1000, 50);
		add_cmd(-1, 1, -1);
		add_cmd(32767, -32768, 0);
		run_phase();

		// wheel overflow and saturation: huge limits and ratio
		reg_write(REG_LIM_VX, 32767);
		reg_write(REG_LIM_VY, 32767);
		reg_write(REG_LIM_TURN, 32767);
		reg_write(REG_RPM_RATIO, 20'hFFFFF);
		reg_write(REG_ROT_ARM, 4095);
		reg_write(REG_OFS_X, 32'h7FF);
		reg_write(REG_OFS_Y, 32'h800);
		reg_write(REG_LIM_WHEEL, 32767);
		add_cmd(32767, 32767, 0);
		add_cmd(-32768, -32768, 32767);
		add_cmd(-32768, 32767, -32768);
		add_cmd(5, 0, 0);
		random_phase(200);

		// zero limits: x and turn forced to zero, wheel limit zero scales to zero
		reg_write(REG_LIM_VX, 0);
		reg_write(REG_LIM_TURN, 0);
		reg_write(REG_LIM_WHEEL, 0);
		add_cmd(32767, 100, 32767);
		add_cmd(0, -100, 0);
		random_phase(150);

		reg_write(REG_LIM_VX, 3300);
		reg_write(REG_LIM_TURN, 300);
		reg_write(REG_LIM_WHEEL, 1);
		random_phase(150);

		// back to defaults, then random settings
		reg_write(REG_ROT_ARM, 375);
		reg_write(REG_OFS_X, 0);
		reg_write(REG_OFS_Y, 0);
		reg_write(REG_RPM_RATIO, 156299);
		reg_write(REG_LIM_VY, 3300);
		reg_write(REG_LIM_WHEEL, 8500);
		random_phase(300);

		for (int p = 0; p < 4; p++) begin
			reg_write(REG_ROT_ARM, $urandom_range(0, 4095));
			reg_write(REG_OFS_X, $urandom);
			reg_write(REG_OFS_Y, $urandom);
			reg_write(REG_RPM_RATIO, $urandom);
			reg_write(REG_LIM_VX, $urandom_range(0, 32767));
			reg_write(REG_LIM_VY, $urandom_range(0, 32767));
			reg_write(REG_LIM_TURN, $urandom_range(0, 2000));
			reg_write(REG_LIM_WHEEL, $urandom_range(1, 32767));
			random_phase(150);
		end

		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/mws_pkg.sv
rtl/mws_fifo.sv
rtl/mws_front.sv
rtl/mws_back.sv
rtl/mecanum_wheel_speed_solver_top.sv
verif/mecanum_wheel_speed_solver_top_tb.sv
